FILE: hdl/pwm_prescale_period_duty_calc_macros.svh
// assertion macros for the pwm prescale / period / duty calculator
// used by the modules in hdl that carry concurrent assertions
`ifndef PWM_PRESCALE_PERIOD_DUTY_CALC_MACROS_SVH
`define PWM_PRESCALE_PERIOD_DUTY_CALC_MACROS_SVH

// property checked on every clock edge outside reset
`define PWMPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define PWMPD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/pwmpd_pkg.sv
// shared types and constants for the pwm prescale / period / duty calculator
// no dependencies
package pwmpd_pkg;

  localparam int unsigned CLOCK_HZ = 48000000;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned CNT_W    = $clog2(DIV_W);
  localparam int unsigned QUOT_W   = $clog2(CLOCK_HZ + 1);
  localparam int unsigned PER_SH   = 15;
  localparam int unsigned HI_W     = QUOT_W - PER_SH;
  localparam int unsigned EXP_W    = 4;
  localparam int unsigned CNT16_W  = 16;
  localparam int unsigned PCT_W    = 7;

  localparam logic [DIV_W-1:0]   CLOCK_HZ_C = DIV_W'(CLOCK_HZ);
  localparam logic [DIV_W-1:0]   DUTY_DIV   = DIV_W'(100);
  localparam logic [15:0]        DUTY_MAX   = 16'd100;
  localparam logic [CNT16_W-1:0] DUTY_MIN   = CNT16_W'(1);
  localparam logic [DIV_W-1:0]   PERIOD_LIM = DIV_W'(32'h7fff);

  localparam logic KIND_FREQ = 1'b0;
  localparam logic KIND_DUTY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/pwmpd_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on pwmpd_pkg
module pwmpd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pwmpd_pkg::div_ctrl_t         ctrl_i,
  input  logic [pwmpd_pkg::DIV_W-1:0]  dividend_i,
  input  logic [pwmpd_pkg::DIV_W-1:0]  divisor_i,
  output pwmpd_pkg::div_stat_t         stat_o,
  output logic [pwmpd_pkg::DIV_W-1:0]  quotient_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [pwmpd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pwmpd_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [pwmpd_pkg::DIV_W-1:0]  quo_q, quo_d;
  logic [pwmpd_pkg::DIV_W-1:0]  dsr_q, dsr_d;
  logic [pwmpd_pkg::DIV_W:0]    shifted;
  logic [pwmpd_pkg::DIV_W:0]    diff;
  logic                         last;

  assign shifted = {rem_q, quo_q[pwmpd_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign last    = (cnt_q == pwmpd_pkg::CNT_W'(pwmpd_pkg::DIV_W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[pwmpd_pkg::DIV_W]) begin
        rem_d = diff[pwmpd_pkg::DIV_W-1:0];
      end else begin
        rem_d = shifted[pwmpd_pkg::DIV_W-1:0];
      end
      quo_d = {quo_q[pwmpd_pkg::DIV_W-2:0], ~diff[pwmpd_pkg::DIV_W]};
      cnt_d = cnt_q + pwmpd_pkg::CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

FILE: hdl/pwm_prescale_period_duty_calc.sv
// A frequency or duty item posts its result through the start step, the 32-step shared
// divider and the finish step; a frequency out of range goes straight to the finish step.
// The input stalls until an item is through; a stalled output holds the finish step, and
// a new item is taken while the previous result waits.
// Reset clears prescale, period and duty registers to zero and empties the output.
// top level, sequencer around pwmpd_div; depends on pwmpd_pkg and the macros header
`include "pwm_prescale_period_duty_calc_macros.svh"
module pwm_prescale_period_duty_calc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [31:0]                    freq_hz_i,
  input  logic [15:0]                    duty_percent_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic [pwmpd_pkg::EXP_W-1:0]    prescale_exp_o,
  output logic [pwmpd_pkg::CNT16_W-1:0]  period_count_o,
  output logic [pwmpd_pkg::CNT16_W-1:0]  duty_count_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                           kind_q, kind_d;
  logic                           err_q, err_d;
  logic [pwmpd_pkg::PCT_W-1:0]    pct_q, pct_d;
  logic                           out_valid_q, out_valid_d;
  logic                           status_q, status_d;
  logic [pwmpd_pkg::EXP_W-1:0]    prescale_q, prescale_d;
  logic [pwmpd_pkg::CNT16_W-1:0]  period_q, period_d;
  logic [pwmpd_pkg::CNT16_W-1:0]  duty_q, duty_d;

  pwmpd_pkg::div_ctrl_t           div_ctrl;
  pwmpd_pkg::div_stat_t           div_stat;
  logic [pwmpd_pkg::DIV_W-1:0]    div_dividend;
  logic [pwmpd_pkg::DIV_W-1:0]    div_divisor;
  logic [pwmpd_pkg::DIV_W-1:0]    quot;

  logic                           in_xfer;
  logic                           slot_free;
  logic                           post_err;
  logic                           freq_bad;
  logic [15:0]                    pct_clamp;
  logic [pwmpd_pkg::HI_W-1:0]     quot_hi;
  logic [pwmpd_pkg::EXP_W-1:0]    top_pos;
  logic [pwmpd_pkg::EXP_W-1:0]    expo;
  logic [pwmpd_pkg::DIV_W-1:0]    quot_sh;
  logic [pwmpd_pkg::DIV_W+pwmpd_pkg::PCT_W-1:0] prod;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign post_err   = (state_q == S_FIN) && slot_free && err_q;
  assign freq_bad   = (freq_hz_i == '0) || (freq_hz_i > pwmpd_pkg::CLOCK_HZ_C);
  assign pct_clamp  = (duty_percent_i > pwmpd_pkg::DUTY_MAX) ? pwmpd_pkg::DUTY_MAX
                                                             : duty_percent_i;

  // prescale exponent from the highest set bit above the period field
  assign quot_hi = quot[pwmpd_pkg::QUOT_W-1:pwmpd_pkg::PER_SH];
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < int'(pwmpd_pkg::HI_W); i++) begin
      if (quot_hi[i]) begin
        top_pos = pwmpd_pkg::EXP_W'(i + 1);
      end
    end
  end
  assign expo    = (quot > pwmpd_pkg::PERIOD_LIM) ? (top_pos - pwmpd_pkg::EXP_W'(1)) : '0;
  assign quot_sh = quot >> expo;
  assign prod    = pct_q * quot;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    err_d        = err_q;
    pct_d        = pct_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    prescale_d   = prescale_q;
    period_d     = period_q;
    duty_d       = duty_q;
    div_ctrl     = '0;
    div_dividend = pwmpd_pkg::CLOCK_HZ_C;
    div_divisor  = freq_hz_i;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          kind_d = kind_i;
          pct_d  = pct_clamp[pwmpd_pkg::PCT_W-1:0];
          err_d  = 1'b0;
          if (kind_i == pwmpd_pkg::KIND_DUTY) begin
            div_dividend   = {period_q, 16'b0};
            div_divisor    = pwmpd_pkg::DUTY_DIV;
            div_ctrl.start = 1'b1;
            state_d        = S_DIV;
          end else if (freq_bad) begin
            err_d   = 1'b1;
            state_d = S_FIN;
          end else begin
            div_ctrl.start = 1'b1;
            state_d        = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (err_q) begin
            status_d = pwmpd_pkg::STATUS_RANGE;
          end else if (kind_q == pwmpd_pkg::KIND_FREQ) begin
            status_d   = pwmpd_pkg::STATUS_OK;
            prescale_d = expo;
            period_d   = quot_sh[pwmpd_pkg::CNT16_W-1:0];
            duty_d     = pwmpd_pkg::DUTY_MIN;
          end else begin
            status_d = pwmpd_pkg::STATUS_OK;
            duty_d   = prod[31:16];
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= pwmpd_pkg::STATUS_OK;
      prescale_q  <= '0;
      period_q    <= '0;
      duty_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      prescale_q  <= prescale_d;
      period_q    <= period_d;
      duty_q      <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    err_q  <= err_d;
    pct_q  <= pct_d;
  end

  pwmpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign prescale_exp_o = prescale_q;
  assign period_count_o = period_q;
  assign duty_count_o   = duty_q;

  `PWMPD_ASSERT(a_start_idle, !div_ctrl.start || !div_stat.busy, "divider started while busy")
  `PWMPD_ASSERT(a_done_in_div, !div_stat.done || (state_q == S_DIV), "divider done outside wait")
  `PWMPD_ASSERT(a_duty_le_period, duty_count_o <= period_count_o, "duty above period")
  `PWMPD_ASSERT_NEXT(a_fin_out, (state_q == S_FIN) && slot_free, out_valid_o, "result not posted")
  `PWMPD_ASSERT_NEXT(a_err_keeps, post_err, $stable({period_q, duty_q}), "range error wrote regs")

endmodule
